// ----- hdl/prse_pkg.sv -----
package prse_pkg;

  localparam int IN_W       = 16;
  localparam int PROD_W     = 32;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_HALF = 'h2000;
  localparam int Q16_SHIFT  = 16;
  localparam int SNR_W      = 32;
  localparam int DIV_STEPS  = 32;
  localparam int CNT_W      = 5;

  typedef struct packed {
    logic load_in;    // capture an input transfer
    logic mul_en;     // H*X partial products
    logic rnd_en;     // rounding and residual
    logic sq_en;      // squared magnitudes
    logic acc_en;     // accumulate, snapshot on last pilot
    logic div_init;   // range check and divider setup
    logic div_step;   // one quotient bit
    logic out_load;   // move result into output register
  } prse_cmd_t;

  typedef struct packed {
    logic last;       // item in flight is the last pilot
    logic out_free;   // output register can take a result this cycle
  } prse_stat_t;

endpackage

// ----- hdl/prse_ctrl.sv -----
module prse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prse_pkg::prse_stat_t stat,
  output prse_pkg::prse_cmd_t  cmd
);
  import prse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RND, S_SQ, S_ACC, S_DSET, S_DIV, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = stat.last ? S_DSET : S_IDLE;
      end
      S_DSET: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/prse_datapath.sv -----
module prse_datapath #(
  parameter int ACC_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prse_pkg::prse_cmd_t  cmd,
  output prse_pkg::prse_stat_t stat,
  input  logic signed [15:0]  in_rx_real,
  input  logic signed [15:0]  in_rx_imag,
  input  logic signed [15:0]  in_chan_real,
  input  logic signed [15:0]  in_chan_imag,
  input  logic signed [15:0]  in_pilot_real,
  input  logic signed [15:0]  in_pilot_imag,
  input  logic                in_last_pilot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_snr_ratio
);
  import prse_pkg::*;

  localparam int WIDE_W = ACC_BITS + Q16_SHIFT;

  // input holding registers
  logic signed [IN_W-1:0] yr_r, yi_r, hr_r, hi_r, xr_r, xi_r;
  logic                   last_r;

  // partial products
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  // rebuilt pilot and residual
  logic signed [PROD_W:0]   full_re, full_im, rnd_re, rnd_im;
  logic signed [IN_W-1:0]   s_re, s_im;
  logic signed [IN_W-1:0]   sr_r, si_r, er_r, ei_r;

  // power terms
  logic signed [PROD_W-1:0] sq_sr, sq_si, sq_er, sq_ei;
  logic [PROD_W-1:0]        pwr_s_r, pwr_e_r;

  // sums
  logic [ACC_BITS-1:0] sig_sum_r, nse_sum_r, sig_sat, nse_sat;
  logic [ACC_BITS:0]   sig_add, nse_add;
  logic [ACC_BITS-1:0] num_r, den_r;

  // divider
  logic [WIDE_W-1:0]   den_x_max;
  logic                sat_r, sat_nxt;
  logic [ACC_BITS-1:0] rem_r;
  logic [ACC_BITS:0]   trial;
  logic                trial_ge;
  logic [SNR_W-1:0]    dlo_r, quot_r;

  logic                out_valid_r;
  logic [SNR_W-1:0]    snr_r;

  always_comb begin
    full_re = (PROD_W+1)'(p_rr_r) - (PROD_W+1)'(p_ii_r);
    full_im = (PROD_W+1)'(p_ri_r) + (PROD_W+1)'(p_ir_r);
    rnd_re  = full_re + (PROD_W+1)'(ROUND_HALF);
    rnd_im  = full_im + (PROD_W+1)'(ROUND_HALF);
    s_re    = rnd_re[FRAC_SHIFT+IN_W-1:FRAC_SHIFT];
    s_im    = rnd_im[FRAC_SHIFT+IN_W-1:FRAC_SHIFT];
  end

  always_comb begin
    sq_sr = PROD_W'(sr_r) * PROD_W'(sr_r);
    sq_si = PROD_W'(si_r) * PROD_W'(si_r);
    sq_er = PROD_W'(er_r) * PROD_W'(er_r);
    sq_ei = PROD_W'(ei_r) * PROD_W'(ei_r);
  end

  // saturating accumulate; sums never exceed their max, so a carry means overflow
  always_comb begin
    sig_add = {1'b0, sig_sum_r} + (ACC_BITS+1)'(pwr_s_r);
    nse_add = {1'b0, nse_sum_r} + (ACC_BITS+1)'(pwr_e_r);
    sig_sat = sig_add[ACC_BITS] ? '1 : sig_add[ACC_BITS-1:0];
    nse_sat = nse_add[ACC_BITS] ? '1 : nse_add[ACC_BITS-1:0];
  end

  // ratio above 65535 when num > den*65535 = (den<<16) - den
  always_comb begin
    den_x_max = {den_r, Q16_SHIFT'(0)} - WIDE_W'(den_r);
    sat_nxt   = (den_r == '0) || (WIDE_W'(num_r) > den_x_max);
    trial     = {rem_r, dlo_r[SNR_W-1]};
    trial_ge  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      yr_r   <= in_rx_real;
      yi_r   <= in_rx_imag;
      hr_r   <= in_chan_real;
      hi_r   <= in_chan_imag;
      xr_r   <= in_pilot_real;
      xi_r   <= in_pilot_imag;
      last_r <= in_last_pilot;
    end
    if (cmd.mul_en) begin
      p_rr_r <= PROD_W'(hr_r) * PROD_W'(xr_r);
      p_ii_r <= PROD_W'(hi_r) * PROD_W'(xi_r);
      p_ri_r <= PROD_W'(hr_r) * PROD_W'(xi_r);
      p_ir_r <= PROD_W'(hi_r) * PROD_W'(xr_r);
    end
    if (cmd.rnd_en) begin
      sr_r <= s_re;
      si_r <= s_im;
      er_r <= yr_r - s_re;
      ei_r <= yi_r - s_im;
    end
    if (cmd.sq_en) begin
      pwr_s_r <= $unsigned(sq_sr) + $unsigned(sq_si);
      pwr_e_r <= $unsigned(sq_er) + $unsigned(sq_ei);
    end
    if (cmd.acc_en && last_r) begin
      num_r <= sig_sat;
      den_r <= nse_sat;
    end
    if (cmd.div_init) begin
      sat_r  <= sat_nxt;
      // quotient fits 32 bits once in range, so the top part starts below den
      rem_r  <= ACC_BITS'(num_r >> Q16_SHIFT);
      dlo_r  <= {num_r[Q16_SHIFT-1:0], Q16_SHIFT'(0)};
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? ACC_BITS'(trial - {1'b0, den_r}) : trial[ACC_BITS-1:0];
      dlo_r  <= {dlo_r[SNR_W-2:0], 1'b0};
      quot_r <= {quot_r[SNR_W-2:0], trial_ge};
    end
    if (cmd.out_load) begin
      snr_r <= sat_r ? '1 : quot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_sum_r   <= '0;
      nse_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc_en) begin
        sig_sum_r <= last_r ? '0 : sig_sat;
        nse_sum_r <= last_r ? '0 : nse_sat;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat = '{last: last_r, out_free: !out_valid_r || out_ready};

  assign out_valid     = out_valid_r;
  assign out_snr_ratio = snr_r;

endmodule

// ----- hdl/pilot_residual_snr_estimator.sv -----
// Pilot SNR estimator: S = H*X (Q1.14 rounded), E = Y - S, sums |S|^2, |E|^2.
// One pilot at a time: accept, multiply, round, square, accumulate.
// After the last pilot's transfer, the range check and radix-2 divider run before the
//   result is registered for output; input stays closed meanwhile.
// Reset (rst_n low, synchronous): both sums cleared, controller idle, no result pending.
module pilot_residual_snr_estimator #(
  parameter int ACC_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_rx_real,
  input  logic signed [15:0] in_rx_imag,
  input  logic signed [15:0] in_chan_real,
  input  logic signed [15:0] in_chan_imag,
  input  logic signed [15:0] in_pilot_real,
  input  logic signed [15:0] in_pilot_imag,
  input  logic               in_last_pilot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_snr_ratio
);
  import prse_pkg::*;

  prse_cmd_t  cmd;
  prse_stat_t stat;

  // Controller: walks each pilot through the datapath steps, then on the last
  // pilot runs the range check and 32 restoring-division steps. The output
  // register is separate, so a result may wait while the next symbol's
  // pilots are taken in.
  prse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: four 16x16 products, rounding/residual, squares, saturating
  // ACC_BITS sums, and a one-bit-per-cycle divider for (signal<<16)/noise.
  // Saturated results (noise zero or ratio above 65535) come out all ones.
  prse_datapath #(
    .ACC_BITS (ACC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_rx_real    (in_rx_real),
    .in_rx_imag    (in_rx_imag),
    .in_chan_real  (in_chan_real),
    .in_chan_imag  (in_chan_imag),
    .in_pilot_real (in_pilot_real),
    .in_pilot_imag (in_pilot_imag),
    .in_last_pilot (in_last_pilot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_snr_ratio (out_snr_ratio)
  );

endmodule

// ----- hdl/prse_checker.sv -----
module prse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_pilot,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_snr_ratio
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_snr_ratio))
    else $error("result changed while stalled");

  // one pilot at a time: input closes after each transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after a transfer");

  // last pilot keeps input closed into the divider setup step
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_pilot |-> ##5 !in_ready)
    else $error("input open during division");

  // a new result appears only as the controller returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

endmodule

bind pilot_residual_snr_estimator prse_checker u_prse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last_pilot (in_last_pilot),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_snr_ratio (out_snr_ratio)
);

// ----- bench/tb_pilot_residual_snr_estimator.sv -----
module tb_pilot_residual_snr_estimator;
  import prse_pkg::*;

  localparam int ACC_W = 48;
  localparam logic [ACC_W-1:0] ACC_FULL = '1;
  localparam logic [SNR_W-1:0] SNR_SATURATED = '1;
  localparam int RATIO_LIMIT = 65535;
  localparam int MAX_PILOTS = 128;
  localparam int QPSK_AMP = 11585;      // 1/sqrt(2) in Q1.14
  localparam int RANDOM_PILOTS = 534;
  localparam int CALM_FROM = 200;       // random pilots in [CALM_FROM, CALM_TO) run with
  localparam int CALM_TO = 350;         // no idling on either side
  localparam int DRAIN_CYCLES = 100;
  localparam int LIMIT_CYCLES = 200_000;

  typedef logic signed [IN_W-1:0] sample_t;

  typedef struct packed {
    sample_t rx_re;
    sample_t rx_im;
    sample_t ch_re;
    sample_t ch_im;
    sample_t pl_re;
    sample_t pl_im;
    logic    last;
  } pilot_t;

  typedef struct packed {
    pilot_t            p;
    logic              has_snr;   // SNR typed in below, else predicted
    logic [SNR_W-1:0]  snr;
  } dir_row_t;

  typedef enum int {
    SYM_NOISY,          // mostly QPSK pilots, random channel scale, Y = S + noise
    SYM_RAW,            // every field random over its full range
    SYM_NOISELESS,      // Y = S exactly, noise sum stays zero
    SYM_NEAR_LIMIT,     // noise of +-1, ratio near or past the clamp
    SYM_DEAD_CHANNEL    // H = 0, signal sum stays zero
  } sym_kind_t;

  // Directed rows: rx, chan, pilot (re, im pairs), last, typed flag, SNR.
  localparam int N_DIR = 16;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    // all zero straight after reset: no noise, clamps
    '{'{0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, 32'hFFFF_FFFF},
    // Y equals H*X: no noise, clamps
    '{'{16384, 0, 16384, 0, 16384, 0, 1'b1}, 1'b1, 32'hFFFF_FFFF},
    // no signal at all
    '{'{1, 0, 0, 0, 0, 0, 1'b1}, 1'b1, 32'h0000_0000},
    // signal power equals noise power
    '{'{0, 0, 16384, 0, 16384, 0, 1'b1}, 1'b1, 32'h0001_0000},
    // 1/5 truncates toward zero
    '{'{3, 1, 1, 0, 16384, 0, 1'b1}, 1'b1, 32'h0000_3333},
    // signal 255^2+22^2+5^2+1^2 = 65535 over noise 1: largest unclamped ratio
    '{'{256, 22, 255, 22, 16384, 0, 1'b0}, 1'b0, 32'h0},
    '{'{5, 1, 5, 1, 16384, 0, 1'b1}, 1'b1, 32'hFFFF_0000},
    // 65536 over 1: just past the clamp
    '{'{257, 0, 256, 0, 16384, 0, 1'b1}, 1'b1, 32'hFFFF_FFFF},
    // field extremes, product and residual wrap
    '{'{0, 0, -32768, -32768, -32768, -32768, 1'b0}, 1'b0, 32'h0},
    '{'{32767, 0, -32768, 0, 16384, 0, 1'b0}, 1'b0, 32'h0},
    '{'{-32768, -32768, 32767, 32767, 32767, -32768, 1'b0}, 1'b0, 32'h0},
    '{'{32767, 32767, -32768, 32767, 32767, -32768, 1'b0}, 1'b0, 32'h0},
    // rounding at exactly one half, both signs
    '{'{0, 0, 1, 0, 8192, 0, 1'b0}, 1'b0, 32'h0},
    '{'{0, 0, -1, 0, 8192, 0, 1'b0}, 1'b0, 32'h0},
    '{'{-1, -1, -1, -1, -1, -1, 1'b1}, 1'b0, 32'h0},
    '{'{-32768, 32767, -32768, 32767, -32768, 32767, 1'b1}, 1'b0, 32'h0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  sample_t          in_rx_real = '0;
  sample_t          in_rx_imag = '0;
  sample_t          in_chan_real = '0;
  sample_t          in_chan_imag = '0;
  sample_t          in_pilot_real = '0;
  sample_t          in_pilot_imag = '0;
  logic             in_last_pilot = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SNR_W-1:0] out_snr_ratio;

  // Bench copy of the block state
  logic [ACC_W-1:0] sig_acc = '0;
  logic [ACC_W-1:0] nse_acc = '0;
  logic [SNR_W-1:0] snr_expected_q [$];

  bit          tx_idle_en = 1'b1;
  bit          rx_stall_en = 1'b1;
  int          pilots_sent = 0;
  int          results_checked = 0;
  int          results_clamped = 0;
  int          mismatch_count = 0;
  logic [SNR_W-1:0] snr_want;

  pilot_residual_snr_estimator #(.ACC_BITS(ACC_W)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_real    (in_rx_real),
    .in_rx_imag    (in_rx_imag),
    .in_chan_real  (in_chan_real),
    .in_chan_imag  (in_chan_imag),
    .in_pilot_real (in_pilot_real),
    .in_pilot_imag (in_pilot_imag),
    .in_last_pilot (in_last_pilot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_snr_ratio (out_snr_ratio)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // (full + 1/2 LSB) >> 14, low 16 bits kept, so large products wrap
  function automatic sample_t round_q14(longint full);
    logic [63:0] v;
    v = full + ROUND_HALF;
    return v[FRAC_SHIFT +: IN_W];
  endfunction

  // S = H*X in Q1.14
  function automatic void rebuild_pilot(input pilot_t p, output sample_t s_re,
                                        output sample_t s_im);
    longint full_re, full_im;
    full_re = longint'(p.ch_re) * longint'(p.pl_re) - longint'(p.ch_im) * longint'(p.pl_im);
    full_im = longint'(p.ch_re) * longint'(p.pl_im) + longint'(p.ch_im) * longint'(p.pl_re);
    s_re = round_q14(full_re);
    s_im = round_q14(full_im);
  endfunction

  function automatic logic [63:0] power_of(sample_t a, sample_t b);
    longint aa, bb;
    aa = longint'(a) * longint'(a);
    bb = longint'(b) * longint'(b);
    return aa + bb;
  endfunction

  // Sums stick at all ones instead of wrapping
  function automatic logic [ACC_W-1:0] add_power(logic [ACC_W-1:0] acc, logic [63:0] pw);
    logic [64:0] sum;
    sum = {17'b0, acc} + {1'b0, pw};
    return (sum > {17'b0, ACC_FULL}) ? ACC_FULL : sum[ACC_W-1:0];
  endfunction

  // (signal << 16) / noise, clamped when noise is zero or the ratio tops 65535
  function automatic logic [SNR_W-1:0] snr_q16(logic [ACC_W-1:0] sig, logic [ACC_W-1:0] nse);
    logic [79:0] ceiling, scaled, quo;
    if (nse == '0) return SNR_SATURATED;
    ceiling = 80'(nse) * 80'(RATIO_LIMIT);
    if (80'(sig) > ceiling) return SNR_SATURATED;
    scaled = 80'(sig) << Q16_SHIFT;
    quo = scaled / 80'(nse);
    return quo[SNR_W-1:0];
  endfunction

  // Called at the edge where the block takes the pilot
  function automatic void accept_pilot(pilot_t p, logic has_snr, logic [SNR_W-1:0] snr);
    sample_t s_re, s_im, e_re, e_im;
    rebuild_pilot(p, s_re, s_im);
    e_re = p.rx_re - s_re;   // residual wraps at 16 bits
    e_im = p.rx_im - s_im;
    sig_acc = add_power(sig_acc, power_of(s_re, s_im));
    nse_acc = add_power(nse_acc, power_of(e_re, e_im));
    pilots_sent++;
    if (p.last) begin
      snr_expected_q.push_back(has_snr ? snr : snr_q16(sig_acc, nse_acc));
      sig_acc = '0;
      nse_acc = '0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic int srand(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic pilot_t make_pilot(sym_kind_t kind, int amp, int nmag);
    pilot_t  p;
    sample_t s_re, s_im;
    int      n_re, n_im;
    p.last = 1'b0;
    p.rx_re = sample_t'($urandom);
    p.rx_im = sample_t'($urandom);
    p.ch_re = sample_t'($urandom);
    p.ch_im = sample_t'($urandom);
    p.pl_re = sample_t'($urandom);
    p.pl_im = sample_t'($urandom);
    if (kind == SYM_RAW) return p;
    if (kind == SYM_DEAD_CHANNEL) begin
      p.ch_re = '0;
      p.ch_im = '0;
      p.rx_re = sample_t'(srand(nmag));
      p.rx_im = sample_t'(srand(nmag));
      return p;
    end
    // mostly QPSK pilots; a few keep their random full-range value
    if ($urandom_range(9) != 0) begin
      p.pl_re = sample_t'($urandom_range(1) ? QPSK_AMP : -QPSK_AMP);
      p.pl_im = sample_t'($urandom_range(1) ? QPSK_AMP : -QPSK_AMP);
    end
    p.ch_re = sample_t'(srand(amp));
    p.ch_im = sample_t'(srand(amp));
    rebuild_pilot(p, s_re, s_im);
    case (kind)
      SYM_NOISELESS: begin
        n_re = 0;
        n_im = 0;
      end
      SYM_NEAR_LIMIT: begin
        n_re = srand(1);
        n_im = srand(1);
      end
      default: begin
        n_re = srand(nmag);
        n_im = srand(nmag);
      end
    endcase
    p.rx_re = sample_t'(s_re + n_re);
    p.rx_im = sample_t'(s_im + n_im);
    return p;
  endfunction

  // One transfer: optional idle, hold valid until in_ready, then predict
  task automatic send_pilot(pilot_t p, logic has_snr, logic [SNR_W-1:0] snr);
    while (tx_idle_en && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_real    <= p.rx_re;
    in_rx_imag    <= p.rx_im;
    in_chan_real  <= p.ch_re;
    in_chan_imag  <= p.ch_im;
    in_pilot_real <= p.pl_re;
    in_pilot_imag <= p.pl_im;
    in_last_pilot <= p.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_pilot(p, has_snr, snr);
    @(negedge clk);
  endtask

  task automatic send_symbol(sym_kind_t kind, int n_pilots);
    pilot_t p;
    int     amp, nmag, sel;
    sel = $urandom_range(3);
    amp = (sel == 0) ? 1024 : (sel == 1) ? 8192 : (sel == 2) ? 16384 : 32767;
    nmag = 1 << $urandom_range(12);
    for (int i = 0; i < n_pilots; i++) begin
      p = make_pilot(kind, amp, nmag);
      p.last = (i == n_pilots - 1);
      send_pilot(p, 1'b0, '0);
    end
  endtask

  // Receiver side: random stalls, none during the calm stretch
  always @(negedge clk) begin
    out_ready <= rx_stall_en ? ($urandom_range(99) >= 8) : 1'b1;
  end

  // ---------------------------------------------------------------------
  // Result check: each SNR transfer against the oldest prediction
  // ---------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [SNR_W-1:0] want, logic [SNR_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (snr_expected_q.size() == 0) begin
        flag_mismatch("SNR result with no symbol pending", '0, out_snr_ratio);
      end else begin
        snr_want = snr_expected_q.pop_front();
        if (out_snr_ratio !== snr_want)
          flag_mismatch($sformatf("snr_ratio of symbol %0d", results_checked), snr_want,
                        out_snr_ratio);
      end
      results_checked++;
      if (out_snr_ratio == SNR_SATURATED) results_clamped++;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    sym_kind_t kind;
    int        r, n_pilots, random_sent;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < N_DIR; i++)
      send_pilot(DIRECTED[i].p, DIRECTED[i].has_snr, DIRECTED[i].snr);

    // Random symbols, mostly well-formed; one stretch runs with no idling
    random_sent = 0;
    while (random_sent < RANDOM_PILOTS) begin
      tx_idle_en = !(random_sent >= CALM_FROM && random_sent < CALM_TO);
      rx_stall_en = tx_idle_en;
      r = $urandom_range(99);
      kind = (r < 55) ? SYM_NOISY : (r < 70) ? SYM_RAW : (r < 80) ? SYM_NOISELESS :
             (r < 92) ? SYM_NEAR_LIMIT : SYM_DEAD_CHANNEL;
      r = $urandom_range(99);
      n_pilots = (r == 0) ? MAX_PILOTS : (r < 10) ? 1 : $urandom_range(16, 2);
      send_symbol(kind, n_pilots);
      random_sent += n_pilots;
    end
    in_valid <= 1'b0;
    tx_idle_en = 1'b1;
    rx_stall_en = 1'b1;

    while (snr_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pilots sent (%0d directed, %0d random in mixed symbols)",
             pilots_sent, N_DIR, random_sent);
    $display("%0d SNR results checked, %0d clamped, %0d mismatches",
             results_checked, results_clamped, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_pilot_residual_snr_estimator: done, clean");
    end else begin
      $display("tb_pilot_residual_snr_estimator: done, errors");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("timeout with %0d SNR results still pending", snr_expected_q.size());
    $display("tb_pilot_residual_snr_estimator: done, errors");
    $finish;
  end

endmodule
